/* hdl/stip_pkg.sv */
package stip_pkg;

    // Value width of the accumulator; the result port stays OUT_W wide
    localparam int VALUE_BITS = 64;
    localparam int OUT_W      = 64;
    localparam int COUNT_W    = 16;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_RESULT = 1'd1;
    localparam logic [BASE_W-1:0]    NUMBER_BASE_RESET = 6'd10;

    // Radix values
    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_UNARY   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 6'd10;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_HEXPFX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_IGNORE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_BAD_BASE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_FINISH    = 2'd0,
        RES_NO_DIGITS = 2'd1,
        RES_BAD_BASE  = 2'd2
    } res_kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]   parsed_value;
        logic [COUNT_W-1:0] chars_consumed;
        logic [1:0]         parse_status;
    } out_item_t;

    typedef struct packed {
        logic                  is_ws;
        logic                  is_sign;
        logic                  is_minus;
        logic                  is_zero;
        logic                  is_x;
        logic                  is_alnum;
        logic [DIGIT_W-1:0]    digit;
    } char_info_t;

    typedef struct packed {
        phase_t                phase;
        logic [VALUE_BITS-1:0] acc;
        logic                  neg;
        logic [BASE_W-1:0]     base;
        logic [COUNT_W-1:0]    cnt;
        logic                  ovf;
    } parse_state_t;

    typedef struct packed {
        res_kind_t             kind;
        logic [VALUE_BITS-1:0] acc;
        logic                  neg;
        logic                  ovf;
        logic [COUNT_W-1:0]    cnt;
    } raw_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_WS,
        acc:   '0,
        neg:   1'b0,
        base:  '0,
        cnt:   '0,
        ovf:   1'b0
    };

endpackage

/* hdl/string_to_integer_parser.sv */
// Channel  Ports                       Carries
// input    s_valid s_ready s_data      one text byte and its last-byte flag
// result   m_valid m_ready m_data      value, bytes consumed, status
// config   cfg_wr_en cfg_index cfg_data radix select, signed/unsigned select
//
// One item per cycle while the raw result register is free or being taken; the
// multiply-by-radix and add of the accumulator are combinational, which sets that rate.
// The path runs through the input register, the parse stage into the raw result
// register, then range check and negation into the output register.
// Reset (aresetn low, synchronous) empties all stages and restarts the parse.
// A stalled output holds; the stages behind it keep filling until the raw
// result register is occupied.
module string_to_integer_parser
    import stip_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    in_item_t          in_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [BASE_W-1:0] number_base_reg;
    logic              signed_result_reg;
    logic              raw_valid_reg;
    logic              raw_valid_next;
    raw_result_t       raw_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;
    logic              emit;
    raw_result_t       raw_result;
    out_item_t         fin_item;
    logic              fin_load;
    logic              raw_free;
    logic              fire;

    stip_step u_step (
        .state_i       (state_reg),
        .item_i        (in_reg),
        .number_base_i (number_base_reg),
        .state_o       (state_next),
        .emit_o        (emit),
        .raw_o         (raw_result)
    );

    stip_finish u_finish (
        .raw_i           (raw_reg),
        .signed_result_i (signed_result_reg),
        .item_o          (fin_item)
    );

    // Stage handshakes
    assign fin_load = raw_valid_reg && (!m_valid_reg || m_ready);
    assign raw_free = !raw_valid_reg || fin_load;
    assign fire     = in_valid_reg && raw_free;
    assign s_ready  = !in_valid_reg || fire;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign raw_valid_next = (fire && emit) ? 1'b1 : (fin_load ? 1'b0 : raw_valid_reg);
    assign m_valid_next   = fin_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            raw_valid_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
            state_reg         <= STATE_RESET;
            number_base_reg   <= NUMBER_BASE_RESET;
            signed_result_reg <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            raw_valid_reg <= raw_valid_next;
            m_valid_reg   <= m_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NUMBER_BASE:   number_base_reg   <= cfg_data[BASE_W-1:0];
                    REG_SIGNED_RESULT: signed_result_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire && emit) begin
            raw_reg <= raw_result;
        end
        if (fin_load) begin
            m_data_reg <= fin_item;
        end
    end

endmodule

/* hdl/stip_char.sv */
module stip_char
    import stip_pkg::*;
(
    input  logic [7:0] char_code_i,
    output char_info_t info_o
);

    logic [7:0] lower;

    // Fold letters to lower case
    assign lower = char_code_i | CASE_BIT;

    // Classify the byte and form its digit value
    always_comb begin
        info_o.is_ws    = (char_code_i inside {CH_SPACE, [CH_TAB:CH_CR]});
        info_o.is_sign  = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS);
        info_o.is_minus = (char_code_i == CH_MINUS);
        info_o.is_zero  = (char_code_i == CH_ZERO);
        info_o.is_x     = (lower == CH_LOWER_X);
        info_o.is_alnum = 1'b0;
        info_o.digit    = '0;
        if (char_code_i inside {[CH_ZERO:CH_NINE]}) begin
            info_o.is_alnum = 1'b1;
            info_o.digit    = DIGIT_W'(char_code_i - CH_ZERO);
        end else if (lower inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            info_o.is_alnum = 1'b1;
            info_o.digit    = DIGIT_W'(lower - CH_LOWER_A) + LETTER_OFFSET;
        end
    end

endmodule

/* hdl/stip_mac.sv */
module stip_mac
    import stip_pkg::*;
(
    input  logic [VALUE_BITS-1:0] acc_i,
    input  logic [BASE_W-1:0]     base_i,
    input  logic [DIGIT_W-1:0]    digit_i,
    output logic [VALUE_BITS-1:0] acc_o,
    output logic                  ovf_o
);

    localparam int WIDE_W = VALUE_BITS + BASE_W;

    logic [WIDE_W-1:0] product;
    logic [WIDE_W-1:0] sum;

    // Multiply by the radix and add the digit; any carry above the value
    // width means the number no longer fits
    assign product = WIDE_W'(acc_i) * WIDE_W'(base_i);
    assign sum     = product + WIDE_W'(digit_i);
    assign acc_o   = sum[VALUE_BITS-1:0];
    assign ovf_o   = |sum[WIDE_W-1:VALUE_BITS];

endmodule

/* hdl/stip_step.sv */
module stip_step
    import stip_pkg::*;
(
    input  parse_state_t      state_i,
    input  in_item_t          item_i,
    input  logic [BASE_W-1:0] number_base_i,
    output parse_state_t      state_o,
    output logic              emit_o,
    output raw_result_t       raw_o
);

    char_info_t            ci;
    logic [VALUE_BITS-1:0] mac_acc;
    logic                  mac_ovf;
    logic                  first_char;
    logic                  bad_base;
    logic [BASE_W-1:0]     base_first;
    logic [BASE_W-1:0]     sn_base_in;
    logic                  sn_auto;
    logic [BASE_W-1:0]     sn_base;
    logic                  dig_in_base;
    logic                  dig_in_sn;
    logic                  dig_in_hex;
    logic [COUNT_W:0]      sum1;
    logic [COUNT_W:0]      sum2;
    logic [COUNT_W-1:0]    cnt_plus1;
    logic [COUNT_W-1:0]    cnt_plus2;
    logic                  take_digit;
    logic                  do_acc;
    logic                  in_ws;
    parse_state_t          nx;
    res_kind_t             kind;
    logic                  emit;

    stip_char u_char (
        .char_code_i (item_i.char_code),
        .info_o      (ci)
    );

    stip_mac u_mac (
        .acc_i   (state_i.acc),
        .base_i  (state_i.base),
        .digit_i (ci.digit),
        .acc_o   (mac_acc),
        .ovf_o   (mac_ovf)
    );

    // Latch the configured radix on the first byte of a string
    assign in_ws      = (state_i.phase == PH_WS);
    assign first_char = (state_i.cnt == '0);
    assign base_first = first_char ? number_base_i : state_i.base;
    assign bad_base   = first_char &&
                        ((number_base_i == BASE_UNARY) || (number_base_i > BASE_MAX));

    // Radix seen by the first character of the number
    assign sn_base_in = in_ws ? base_first : state_i.base;
    assign sn_auto    = (sn_base_in == BASE_AUTO);
    assign sn_base    = sn_auto ? BASE_DECIMAL : sn_base_in;

    assign dig_in_base = ci.is_alnum && (ci.digit < state_i.base);
    assign dig_in_sn   = ci.is_alnum && (ci.digit < sn_base);
    assign dig_in_hex  = ci.is_alnum && (ci.digit < BASE_HEX);

    // Saturating character counts
    assign sum1      = {1'b0, state_i.cnt} + (COUNT_W+1)'(1);
    assign sum2      = {1'b0, state_i.cnt} + (COUNT_W+1)'(2);
    assign cnt_plus1 = sum1[COUNT_W] ? '1 : sum1[COUNT_W-1:0];
    assign cnt_plus2 = sum2[COUNT_W] ? '1 : sum2[COUNT_W-1:0];

    // Advance the parse by one byte
    always_comb begin
        nx         = state_i;
        emit       = 1'b0;
        kind       = RES_FINISH;
        take_digit = 1'b0;
        do_acc     = 1'b0;
        case (state_i.phase)
            PH_WS, PH_SIGNED: begin
                if (in_ws) begin
                    nx.base = base_first;
                end
                if (in_ws && bad_base) begin
                    emit = 1'b1;
                    kind = RES_BAD_BASE;
                end else if (in_ws && ci.is_ws) begin
                    nx.cnt = cnt_plus1;
                end else if (in_ws && ci.is_sign) begin
                    nx.neg   = ci.is_minus;
                    nx.cnt   = cnt_plus1;
                    nx.phase = PH_SIGNED;
                end else if (sn_auto && ci.is_zero) begin
                    nx.base  = BASE_OCTAL;
                    nx.acc   = '0;
                    nx.cnt   = cnt_plus1;
                    nx.phase = PH_ZERO;
                end else begin
                    nx.base = sn_base;
                    if (dig_in_sn) begin
                        nx.acc   = VALUE_BITS'(ci.digit);
                        nx.cnt   = cnt_plus1;
                        nx.phase = PH_DIGITS;
                    end else begin
                        emit = 1'b1;
                        kind = RES_NO_DIGITS;
                    end
                end
            end
            PH_ZERO: begin
                if (ci.is_x) begin
                    nx.base  = BASE_HEX;
                    nx.phase = PH_HEXPFX;
                end else begin
                    nx.phase   = PH_DIGITS;
                    take_digit = 1'b1;
                end
            end
            PH_HEXPFX: begin
                if (dig_in_hex) begin
                    nx.cnt   = cnt_plus2;
                    nx.phase = PH_DIGITS;
                    do_acc   = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_DIGITS: begin
                take_digit = 1'b1;
            end
            default: begin
            end
        endcase

        // Take a digit of the active radix or end the number
        if (take_digit) begin
            if (dig_in_base) begin
                nx.cnt = cnt_plus1;
                do_acc = 1'b1;
            end else begin
                emit = 1'b1;
                kind = RES_FINISH;
            end
        end

        // Accumulate unless the value has already overflowed
        if (do_acc && !state_i.ovf) begin
            if (mac_ovf) begin
                nx.ovf = 1'b1;
            end else begin
                nx.acc = mac_acc;
            end
        end

        // Close the number at the end of the string
        if (!emit && item_i.last_char && (state_i.phase != PH_IGNORE)) begin
            emit = 1'b1;
            kind = ((nx.phase == PH_WS) || (nx.phase == PH_SIGNED)) ?
                   RES_NO_DIGITS : RES_FINISH;
        end

        raw_o.kind = kind;
        raw_o.acc  = nx.acc;
        raw_o.neg  = nx.neg;
        raw_o.ovf  = nx.ovf;
        raw_o.cnt  = nx.cnt;

        // Restart on the last byte, otherwise drop the rest of the string once a result is emitted
        if (item_i.last_char) begin
            nx = STATE_RESET;
        end else if (emit) begin
            nx.phase = PH_IGNORE;
        end

        state_o = nx;
        emit_o  = emit;
    end

endmodule

/* hdl/stip_finish.sv */
module stip_finish
    import stip_pkg::*;
(
    input  raw_result_t raw_i,
    input  logic        signed_result_i,
    output out_item_t   item_o
);

    logic [VALUE_BITS-1:0] negated;
    logic [VALUE_BITS-1:0] value;
    logic                  range_err;

    assign negated = VALUE_BITS'(0) - raw_i.acc;
    assign value   = raw_i.neg ? negated : raw_i.acc;

    // Signed range: up to 2^(N-1) when negative, below it when positive
    assign range_err = signed_result_i &&
                       (raw_i.neg ? (raw_i.acc[VALUE_BITS-1] && |raw_i.acc[VALUE_BITS-2:0])
                                  : raw_i.acc[VALUE_BITS-1]);

    // Map the raw outcome to value, count and status
    always_comb begin
        item_o.parsed_value   = '0;
        item_o.chars_consumed = '0;
        item_o.parse_status   = ST_OK;
        case (raw_i.kind)
            RES_NO_DIGITS: item_o.parse_status = ST_NO_DIGITS;
            RES_BAD_BASE:  item_o.parse_status = ST_BAD_BASE;
            RES_FINISH: begin
                if (raw_i.ovf || range_err) begin
                    item_o.parse_status = ST_OVERFLOW;
                end else begin
                    item_o.chars_consumed = raw_i.cnt;
                    item_o.parsed_value   = signed_result_i ? OUT_W'(signed'(value))
                                                            : OUT_W'(value);
                end
            end
            default: item_o.parse_status = ST_NO_DIGITS;
        endcase
    end

endmodule
